// ===== rtl/oblr_pkg.sv =====
// oblr_pkg: shared field widths and word-kind codes for the byte log ring.
// No dependencies. Used by overwriting_byte_log_ring and oblr_checker.
package oblr_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned OFF_W     = 13;
  localparam int unsigned LEN_W     = 7;
  localparam int unsigned CNT_OUT_W = 14;

  typedef enum logic {
    KIND_APPEND = 1'b0,
    KIND_READ   = 1'b1
  } kind_e;

  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [OFF_W-1:0]     off_t;
  typedef logic [LEN_W-1:0]     len_t;
  typedef logic [CNT_OUT_W-1:0] cnt_out_t;

endpackage

// ===== rtl/overwriting_byte_log_ring.sv =====
// overwriting_byte_log_ring: DEPTH-entry byte ring that overwrites the oldest byte.
// Depends on oblr_pkg. Checked by oblr_checker (bound in its own file).
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+---------------------------------------------
//  in      | in  | in_valid_i/in_ready_o | kind_i append_byte_i read_offset_i read_length_i
//  out     | out | out_valid_o/out_ready_i | out_byte_o has_data_o last_of_run_o stored_count_o
//
// Append word: registered count word reply; one append per cycle while out is taken each cycle.
// Read word: setup steps SETUP and START, then per byte a memory read and an output load;
//   an empty read skips from SETUP to LOAD. The sequencer's read/load step pair sets the byte pace.
// Reset clears head, count and control; ring contents are undefined until written.
// A stalled out word holds the sequencer; in_ready_o is low during a read run.
module overwriting_byte_log_ring #(
  parameter int unsigned DEPTH    = 8192,
  parameter int unsigned MAX_READ = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              kind_i,
  input  oblr_pkg::byte_t   append_byte_i,
  input  oblr_pkg::off_t    read_offset_i,
  input  oblr_pkg::len_t    read_length_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output oblr_pkg::byte_t   out_byte_o,
  output logic              has_data_o,
  output logic              last_of_run_o,
  output oblr_pkg::cnt_out_t stored_count_o
);
  import oblr_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = $clog2(MAX_READ + 1);
  localparam int unsigned XW = (CW > OFF_W) ? CW : OFF_W;
  localparam int unsigned SW = XW + 2;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SETUP = 5'b00010,
    ST_START = 5'b00100,
    ST_READ  = 5'b01000,
    ST_LOAD  = 5'b10000
  } state_e;

  state_e          state_q, state_d;
  logic [AW-1:0]   wp_q, wp_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [AW-1:0]   addr_q, addr_d;
  logic [LW-1:0]   n_q, n_d;
  logic            empty_q, empty_d;
  off_t            off_q, off_d;
  logic [LW-1:0]   len_q, len_d;
  logic [SW-1:0]   t_q, t_d;

  logic            out_valid_q, out_valid_d;
  byte_t           out_byte_q, out_byte_d;
  logic            has_data_q, has_data_d;
  logic            last_q, last_d;
  cnt_out_t        out_cnt_q, out_cnt_d;

  logic [BYTE_W-1:0] byte_mem [DEPTH];
  byte_t           rd_data_q;
  logic            wr_en, rd_en;

  logic            in_fire, out_free;
  logic [LW-1:0]   len_sat;
  logic [XW:0]     avail;
  logic            empty_now;
  logic [SW-1:0]   d0, d1;
  logic [AW-1:0]   addr_inc;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;

  assign len_sat = (read_length_i > LEN_W'(MAX_READ)) ? LW'(MAX_READ) : LW'(read_length_i);

  assign avail     = {1'b0, XW'(cnt_q)} - {1'b0, XW'(off_q)};
  assign empty_now = avail[XW] || (avail == '0) || (len_q == '0);

  assign d0 = t_q - SW'(cnt_q);
  assign d1 = t_q + SW'(DEPTH) - SW'(cnt_q);

  assign addr_inc = (addr_q == AW'(DEPTH - 1)) ? '0 : addr_q + AW'(1);

  assign wr_en = in_fire && (kind_i == KIND_APPEND);
  assign rd_en = (state_q == ST_READ);

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    cnt_d       = cnt_q;
    addr_d      = addr_q;
    n_d         = n_q;
    empty_d     = empty_q;
    off_d       = off_q;
    len_d       = len_q;
    t_d         = t_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    has_data_d  = has_data_q;
    last_d      = last_q;
    out_cnt_d   = out_cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (kind_i == KIND_APPEND) begin
            wp_d  = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
            cnt_d = (cnt_q == CW'(DEPTH)) ? cnt_q : cnt_q + CW'(1);
            out_valid_d = 1'b1;
            out_byte_d  = '0;
            has_data_d  = 1'b0;
            last_d      = 1'b1;
            out_cnt_d   = CNT_OUT_W'(cnt_d);
          end else begin
            off_d   = read_offset_i;
            len_d   = len_sat;
            state_d = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        empty_d = empty_now;
        n_d     = (avail > (XW + 1)'(len_q)) ? len_q : LW'(avail);
        t_d     = SW'(wp_q) + SW'(off_q);
        state_d = empty_now ? ST_LOAD : ST_START;
      end
      ST_START: begin
        addr_d  = d0[SW-1] ? AW'(d1) : AW'(d0);
        state_d = ST_READ;
      end
      ST_READ: begin
        addr_d  = addr_inc;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_cnt_d   = CNT_OUT_W'(cnt_q);
          if (empty_q) begin
            out_byte_d = '0;
            has_data_d = 1'b0;
            last_d     = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            out_byte_d = rd_data_q;
            has_data_d = 1'b1;
            last_d     = (n_q == LW'(1));
            n_d        = n_q - LW'(1);
            state_d    = (n_q == LW'(1)) ? ST_IDLE : ST_READ;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    n_q        <= n_d;
    empty_q    <= empty_d;
    off_q      <= off_d;
    len_q      <= len_d;
    t_q        <= t_d;
    out_byte_q <= out_byte_d;
    has_data_q <= has_data_d;
    last_q     <= last_d;
    out_cnt_q  <= out_cnt_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      byte_mem[wp_q] <= append_byte_i;
    end
    if (rd_en) begin
      rd_data_q <= byte_mem[addr_q];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign has_data_o     = has_data_q;
  assign last_of_run_o  = last_q;
  assign stored_count_o = out_cnt_q;

endmodule

// ===== rtl/oblr_checker.sv =====
// oblr_checker: port-level assertions for overwriting_byte_log_ring.
// Depends on oblr_pkg; bound to overwriting_byte_log_ring at the end of this file.
module oblr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               kind_i,
  input oblr_pkg::byte_t    append_byte_i,
  input oblr_pkg::off_t     read_offset_i,
  input oblr_pkg::len_t     read_length_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input oblr_pkg::byte_t    out_byte_o,
  input logic               has_data_o,
  input logic               last_of_run_o,
  input oblr_pkg::cnt_out_t stored_count_o
);
  import oblr_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(has_data_o) && $stable(last_of_run_o) && $stable(stored_count_o))
    else $error("out word changed while stalled");

  a_nodata_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_data_o |-> last_of_run_o && (out_byte_o == '0))
    else $error("non-data word not a zero last word");

  a_append_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (kind_i == KIND_APPEND)
      |=> out_valid_o && !has_data_o && last_of_run_o)
    else $error("append gave no count word");

  a_run_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_data_o && !last_of_run_o |-> !in_ready_o)
    else $error("input taken during a read run");

endmodule

bind overwriting_byte_log_ring oblr_checker u_oblr_checker (.*);
